// ----- rtl/rlegd_pkg.sv -----
// Shared types, constants and helpers of the run-length grey row decoder.
package rlegd_pkg;

    localparam int unsigned DIAMETER_DEF = 240;
    localparam logic [15:0] BG_RESET     = 16'hFFFF;
    localparam int unsigned MAX_RESULTS  = 3;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_SKIP  = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       new_frame;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  x_start;
        logic [7:0]  row_index;
        logic [7:0]  run_length;
        logic [15:0] colour;
        logic        row_last;
    } out_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] bytes_left;
        logic [7:0] left_skip;
        logic [7:0] pixels_done;
        logic [7:0] row_counter;
    } state_t;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    // Grey level 32*level3 packed as RGB565.
    function automatic logic [15:0] grey565(input logic [2:0] level3);
        logic [7:0] c;
        begin
            c = {level3, 5'b00000};
            grey565 = ({8'h00, c & 8'hF8} << 8) | ({8'h00, c & 8'hFC} << 3)
                      | {8'h00, c >> 3};
        end
    endfunction

    // Saturating 8-bit add.
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[8] ? 8'hFF : s[7:0];
        end
    endfunction

endpackage

// ----- rtl/rlegd_step.sv -----
// Combinational decode of one code byte: next state and up to three results.
module rlegd_step #(
    parameter int unsigned DIAMETER = rlegd_pkg::DIAMETER_DEF
) (
    input  rlegd_pkg::state_t         cur,
    input  rlegd_pkg::in_t            item,
    input  logic [15:0]               background,
    output rlegd_pkg::state_t         nxt,
    output rlegd_pkg::out_t [2:0]     res,
    output logic [1:0]                res_count
);
    import rlegd_pkg::*;

    localparam logic [8:0] DIAM9 = 9'(DIAMETER);

    phase_t     ph;
    logic [7:0] row;
    logic [7:0] b;
    logic [7:0] skip_sel;
    logic [8:0] twice;
    logic [7:0] width;
    logic [7:0] pix1;
    logic [7:0] pix2;
    logic [7:0] pix_end;
    logic [7:0] rest;
    logic [7:0] bl_dec;
    logic [8:0] row_inc;
    logic [7:0] row_wrap;
    out_t       fill_close;

    always_comb
    begin
        b        = item.code_byte;
        ph       = item.new_frame ? PH_COUNT : cur.phase;
        row      = item.new_frame ? 8'd0 : cur.row_counter;
        skip_sel = (ph == PH_SKIP) ? b : cur.left_skip;
        twice    = {skip_sel, 1'b0};
        width    = (DIAM9 > twice) ? 8'(DIAM9 - twice) : 8'd0;
        pix1     = sat_add(cur.pixels_done, b[7] ? 8'd1 : b);
        pix2     = sat_add(pix1, 8'd1);
        pix_end  = (b[7] && b[3]) ? pix2 : pix1;
        if (ph == PH_SKIP)
        begin
            pix_end = 8'd0;
        end
        rest     = (width > pix_end) ? (width - pix_end) : 8'd0;
        bl_dec   = cur.bytes_left - 8'd1;
        row_inc  = {1'b0, row} + 9'd1;
        row_wrap = (row_inc >= DIAM9) ? 8'd0 : row_inc[7:0];

        fill_close = '{kind: KIND_FILL, x_start: 8'd0, row_index: row,
                       run_length: rest, colour: background, row_last: 1'b1};

        nxt             = cur;
        nxt.phase       = ph;
        nxt.row_counter = row;
        res             = '0;
        res_count       = 2'd0;

        unique case (ph)
            PH_COUNT:
            begin
                nxt.bytes_left  = b;
                nxt.pixels_done = 8'd0;
                nxt.phase       = PH_SKIP;
            end
            PH_SKIP:
            begin
                nxt.left_skip   = b;
                nxt.pixels_done = 8'd0;
                res[0] = '{kind: KIND_WINDOW, x_start: b, row_index: row,
                           run_length: width, colour: 16'd0, row_last: 1'b0};
                if (cur.bytes_left == 8'd0)
                begin
                    // Empty row: the window is closed at once.
                    res[1]          = fill_close;
                    res_count       = 2'd2;
                    nxt.row_counter = row_wrap;
                    nxt.phase       = PH_COUNT;
                    nxt.bytes_left  = 8'd0;
                end
                else
                begin
                    res_count = 2'd1;
                    nxt.phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (b[7])
                begin
                    res[0] = '{kind: KIND_FILL, x_start: 8'd0, row_index: row,
                               run_length: 8'd1, colour: grey565(b[6:4]),
                               row_last: 1'b0};
                    if (b[3])
                    begin
                        res[1] = '{kind: KIND_FILL, x_start: 8'd0, row_index: row,
                                   run_length: 8'd1, colour: grey565(b[2:0]),
                                   row_last: 1'b0};
                        res_count = 2'd2;
                    end
                    else
                    begin
                        res_count = 2'd1;
                    end
                end
                else
                begin
                    res[0] = '{kind: KIND_FILL, x_start: 8'd0, row_index: row,
                               run_length: b, colour: background, row_last: 1'b0};
                    res_count = 2'd1;
                end
                nxt.pixels_done = pix_end;
                nxt.bytes_left  = bl_dec;
                if (bl_dec == 8'd0)
                begin
                    // Last data byte: append the fill that finishes the row.
                    res[res_count]  = fill_close;
                    res_count       = res_count + 2'd1;
                    nxt.row_counter = row_wrap;
                    nxt.phase       = PH_COUNT;
                    nxt.pixels_done = 8'd0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- rtl/rle_grey_row_decoder_top.sv -----
// Top level of the run-length grey row decoder for a round display.
//
// The block takes one coded byte per input transaction (in_valid/in_stall,
// payload in_item) and delivers results one per output transaction
// (out_valid/out_stall, payload out_item). Each row is a count byte, a skip
// byte that opens the row window, and count data bytes that produce grey
// pixels or background runs; the row is closed by a background fill.
// A byte is first held in an input register; once the result group is
// empty or giving up its last result, the decode logic turns it into zero
// to three results, which land together in a three-entry result group that
// drains one result per cycle while out_stall is low. A byte's results are
// registered in the result group before they are offered. A steady stream
// of bytes that make at most one result each runs at one byte per cycle
// while out_stall is low; a byte that makes more results holds the stream
// until the single output port drains the last result of the group.
// When the receiver raises out_stall the group holds and, with a byte waiting
// in the input register, in_stall rises in that same cycle; nothing is lost.
// Reset clears all decoder state, empties both stages and sets the
// background colour to white. The colour register is written through the
// cfg channel, which is always ready, and must only change while idle.
module rle_grey_row_decoder_top #(
    parameter int unsigned DIAMETER = rlegd_pkg::DIAMETER_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rlegd_pkg::in_t  in_item,
    output logic            out_valid,
    input  logic            out_stall,
    output rlegd_pkg::out_t out_item,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data
);
    import rlegd_pkg::*;

    // Input register stage.
    logic       item_valid_reg;
    logic       item_valid_next;
    in_t        item_reg;

    // Decoder state and the background colour register.
    state_t      state_reg;
    state_t      state_next;
    logic [15:0] bg_reg;

    // Result group: up to three results from one byte, drained in order.
    out_t [2:0] grp_reg;
    out_t [2:0] grp_next;
    logic [1:0] grp_cnt_reg;
    logic [1:0] grp_cnt_next;

    out_t [2:0] step_res;
    logic [1:0] step_cnt;
    logic       out_take;
    logic       advance;
    logic       in_take;

    rlegd_step #(
        .DIAMETER(DIAMETER)
    ) u_step (
        .cur        (state_reg),
        .item       (item_reg),
        .background (bg_reg),
        .nxt        (state_next),
        .res        (step_res),
        .res_count  (step_cnt)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = (grp_cnt_reg != 2'd0);
    assign out_item  = grp_reg[0];
    assign out_take  = out_valid && !out_stall;

    // The held byte is decoded once the group is empty or is giving up its
    // last result in this cycle.
    assign advance  = item_valid_reg &&
                      ((grp_cnt_reg == 2'd0) || ((grp_cnt_reg == 2'd1) && out_take));
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        grp_next     = grp_reg;
        grp_cnt_next = grp_cnt_reg;
        if (advance)
        begin
            grp_next     = step_res;
            grp_cnt_next = step_cnt;
        end
        else if (out_take)
        begin
            grp_next[0]  = grp_reg[1];
            grp_next[1]  = grp_reg[2];
            grp_cnt_next = grp_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg        <= 1'b0;
            grp_cnt_reg           <= 2'd0;
            bg_reg                <= BG_RESET;
            state_reg.phase       <= PH_COUNT;
            state_reg.bytes_left  <= 8'd0;
            state_reg.left_skip   <= 8'd0;
            state_reg.pixels_done <= 8'd0;
            state_reg.row_counter <= 8'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            grp_cnt_reg    <= grp_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                bg_reg <= cfg_data;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
        grp_reg <= grp_next;
    end

endmodule
